>>> hdl/tsu_pkg.sv
// ----------------------------------------------------------------------------
// tsu_pkg
// Shared types, constants and helpers of the Taylor-series trig unit.
// ----------------------------------------------------------------------------
package tsu_pkg;

    localparam int MAX_TERMS = 48;
    localparam int FRAC_BITS = 28;

    localparam int W      = 64;           // internal word
    localparam int ARG_W  = 34;           // angle plus pi/2, signed
    localparam int AMAG_W = ARG_W - 1;
    localparam int ACC_W  = 63 + AMAG_W;  // term magnitude times argument magnitude
    localparam int R_W    = ACC_W - FRAC_BITS;
    localparam int K_W    = 8;
    localparam int D_W    = 2 * K_W;
    localparam int N_W    = $clog2(MAX_TERMS + 1);
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = W / DIV_BITS;
    localparam int QDIV_STEPS = 2 * W;
    localparam int CNT_W  = $clog2(QDIV_STEPS);
    localparam int Q_W    = 42;

    localparam logic [W-1:0] LIM = 64'h4000_0000_0000_0000;
    localparam logic signed [W:0] LIM65  = 65'sh0_4000_0000_0000_0000;
    localparam logic signed [W:0] NLIM65 = -LIM65;
    localparam logic [W-1:0] PI_HALF_Q62 = 64'h6487_ED51_10B4_611A;
    localparam logic [W-1:0] PI_HALF =
        (PI_HALF_Q62 + (64'd1 << (61 - FRAC_BITS))) >> (62 - FRAC_BITS);
    localparam logic signed [ARG_W-1:0] PI_ARG = PI_HALF[ARG_W-1:0];
    localparam logic [Q_W-1:0] Q_BIG = 42'd1 << 40;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

    localparam logic       REG_THR   = 1'b0;
    localparam logic [15:0] THR_RESET = 16'd3;

    typedef enum logic [1:0] {
        OP_SIN = 2'd0,
        OP_COS = 2'd1,
        OP_TAN = 2'd2,
        OP_COT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL_LO,
        S_MUL_HI,
        S_MUL_RND,
        S_DIV_INIT,
        S_DIV,
        S_DIV_END,
        S_NEXT,
        S_QDIV,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic init_cos;
        logic add_term;
        logic mul_lo;
        logic mul_sel;
        logic mul_hi;
        logic mul_rnd;
        logic div_init;
        logic div_step;
        logic div_end;
        logic q_init;
        logic q_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic term_small;
    } dp_stat_t;

    function automatic logic [W-1:0] mag64(input logic signed [W-1:0] a);
        logic [W-1:0] r;
        r = a[W-1] ? (~a + 64'd1) : a;
        return r;
    endfunction

endpackage

>>> hdl/tsu_ctrl.sv
// ----------------------------------------------------------------------------
// tsu_ctrl
// Sequencer: series term loop, tan/cot second pass, long division, result.
// ----------------------------------------------------------------------------
module tsu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              op_quot,
    input  tsu_pkg::dp_stat_t stat,
    output tsu_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import tsu_pkg::*;

    state_t           state_reg, state_next;
    logic [N_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             sel_reg, sel_next;
    logic             pass_reg, pass_next;
    logic             tc_reg, tc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            cnt_reg   <= '0;
            sel_reg   <= 1'b0;
            pass_reg  <= 1'b0;
            tc_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            cnt_reg   <= cnt_next;
            sel_reg   <= sel_next;
            pass_reg  <= pass_next;
            tc_reg    <= tc_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        cnt_next   = cnt_reg;
        sel_next   = sel_reg;
        pass_next  = pass_reg;
        tc_next    = tc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CHECK;
                    n_next     = '0;
                    pass_next  = 1'b0;
                    tc_next    = op_quot;
                end
            end
            S_CHECK:
            begin
                if (n_reg == N_W'(MAX_TERMS) || stat.term_small)
                    state_next = S_NEXT;
                else
                begin
                    state_next = S_MUL_LO;
                    sel_next   = 1'b0;
                end
            end
            S_MUL_LO:  state_next = S_MUL_HI;
            S_MUL_HI:  state_next = S_MUL_RND;
            S_MUL_RND:
            begin
                if (!sel_reg)
                begin
                    sel_next   = 1'b1;
                    state_next = S_MUL_LO;
                end
                else
                    state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    state_next = S_DIV_END;
            end
            S_DIV_END:
            begin
                n_next     = n_reg + 1'b1;
                state_next = S_CHECK;
            end
            S_NEXT:
            begin
                if (tc_reg && !pass_reg)
                begin
                    pass_next  = 1'b1;
                    n_next     = '0;
                    state_next = S_CHECK;
                end
                else if (tc_reg)
                begin
                    cnt_next   = '0;
                    state_next = S_QDIV;
                end
                else
                    state_next = S_FINISH;
            end
            S_QDIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QDIV_STEPS - 1))
                    state_next = S_FINISH;
            end
            S_FINISH:  state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd     = '0;
        busy    = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:     cmd.load = start;
            S_CHECK:    cmd.add_term = !(n_reg == N_W'(MAX_TERMS) || stat.term_small);
            S_MUL_LO:
            begin
                cmd.mul_lo  = 1'b1;
                cmd.mul_sel = sel_reg;
            end
            S_MUL_HI:   cmd.mul_hi = 1'b1;
            S_MUL_RND:  cmd.mul_rnd = 1'b1;
            S_DIV_INIT: cmd.div_init = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_DIV_END:  cmd.div_end = 1'b1;
            S_NEXT:
            begin
                cmd.init_cos = tc_reg && !pass_reg;
                cmd.q_init   = tc_reg && pass_reg;
            end
            S_QDIV:     cmd.q_step = 1'b1;
            S_FINISH:   cmd.finish = 1'b1;
            default:    cmd = '0;
        endcase
    end

endmodule

>>> hdl/tsu_dp.sv
// ----------------------------------------------------------------------------
// tsu_dp
// Datapath: series registers, split multiplier, radix-16 term divider,
// restoring quotient divider and result formatting.
// ----------------------------------------------------------------------------
module tsu_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  tsu_pkg::dp_cmd_t  cmd,
    input  logic [1:0]        op_in,
    input  logic signed [31:0] angle_in,
    input  logic [15:0]       thr,
    output tsu_pkg::dp_stat_t stat,
    output logic              done,
    output logic signed [31:0] value,
    output logic [1:0]        status
);
    import tsu_pkg::*;

    op_t                     op_reg;
    logic signed [ARG_W-1:0] x_reg, arg_reg;
    logic [AMAG_W-1:0]       amag_reg;
    logic signed [W-1:0]     term_reg, sum_reg, s_reg, p_reg;
    logic                    ovf_reg;
    logic [K_W-1:0]          k_reg;
    logic [D_W-1:0]          d_reg;
    logic [62:0]             mop_reg;
    logic                    mneg_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [W-1:0]            dsh_reg, dq_reg;
    logic [D_W-1:0]          drem_reg;
    logic [2*W-1:0]          qn_reg;
    logic [W-1:0]            qd_reg, qrem_reg;
    logic [Q_W-1:0]          qq_reg;
    logic                    big_reg;
    logic                    done_reg;
    logic signed [31:0]      value_reg;
    status_t                 status_reg;

    // series start value
    logic signed [ARG_W-1:0] x_ext, arg_new;
    logic [ARG_W-1:0]        arg_abs;

    assign x_ext   = ARG_W'(angle_in);
    assign arg_new = cmd.load ? ((op_t'(op_in) == OP_COS) ? x_ext + PI_ARG : x_ext)
                              : x_reg + PI_ARG;
    assign arg_abs = arg_new[ARG_W-1] ? -arg_new : arg_new;

    // saturating accumulate
    logic signed [W:0]   sum65;
    logic signed [W-1:0] sum_new;
    logic                sum_ovf;

    always_comb
    begin
        sum65   = 65'(sum_reg) + 65'(term_reg);
        sum_ovf = 1'b0;
        sum_new = sum65[W-1:0];
        if (sum65 > LIM65)
        begin
            sum_ovf = 1'b1;
            sum_new = LIM;
        end
        else if (sum65 < NLIM65)
        begin
            sum_ovf = 1'b1;
            sum_new = -LIM;
        end
    end

    // multiplier: low half, then high half, then round
    logic [W-1:0]        src_mag;
    logic [64:0]         plo;
    logic [63:0]         phi;
    logic [ACC_W-1:0]    rsum;
    logic [R_W-1:0]      rq;
    logic                r_ovf;
    logic [W-1:0]        r64;

    assign src_mag = mag64(cmd.mul_sel ? p_reg : term_reg);
    assign plo     = {33'b0, src_mag[31:0]} * {32'b0, amag_reg};
    assign phi     = {33'b0, mop_reg[62:32]} * {31'b0, amag_reg};
    assign rsum    = acc_reg + (ACC_W'(1) << (FRAC_BITS - 1));
    assign rq      = rsum[ACC_W-1:FRAC_BITS];
    assign r_ovf   = rq > R_W'(LIM);
    assign r64     = r_ovf ? LIM : rq[W-1:0];

    // term divider, DIV_BITS quotient bits a cycle
    logic [D_W:0]   dr;
    logic [W-1:0]   dsh, dq;
    logic [K_W-1:0] k_nx;

    always_comb
    begin
        dr  = {1'b0, drem_reg};
        dsh = dsh_reg;
        dq  = dq_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            dr  = {dr[D_W-1:0], dsh[W-1]};
            dsh = {dsh[W-2:0], 1'b0};
            if (dr >= {1'b0, d_reg})
            begin
                dr = dr - {1'b0, d_reg};
                dq = {dq[W-2:0], 1'b1};
            end
            else
                dq = {dq[W-2:0], 1'b0};
        end
    end

    assign k_nx = k_reg + K_W'(2);

    // quotient divider
    logic signed [W-1:0] num, den;
    logic [W:0]          qsh;
    logic                qge;

    assign num = (op_reg == OP_TAN) ? s_reg : sum_reg;
    assign den = (op_reg == OP_TAN) ? sum_reg : s_reg;
    assign qsh = {qrem_reg, qn_reg[2*W-1]};
    assign qge = qsh >= {1'b0, qd_reg};

    // result formatting
    logic [Q_W-1:0]      qr, qf;
    logic signed [W-1:0] qv, cv;
    logic                qneg;
    logic signed [31:0]  v_next;
    status_t             st_next;

    always_comb
    begin
        qneg = num[W-1] ^ den[W-1];
        qr   = qq_reg + Q_W'(!big_reg && ({qrem_reg, 1'b0} >= {1'b0, qd_reg}));
        qf   = (big_reg || qr > Q_BIG) ? Q_BIG : qr;
        qv   = qneg ? -W'(qf) : W'(qf);
        cv   = op_reg[1] ? qv : sum_reg;
        if (cv > W'(VAL_MAX))
        begin
            v_next  = VAL_MAX;
            st_next = ST_SAT;
        end
        else if (cv < W'(VAL_MIN))
        begin
            v_next  = VAL_MIN;
            st_next = ST_SAT;
        end
        else
        begin
            v_next  = cv[31:0];
            st_next = ST_OK;
        end
        if (!op_reg[1])
        begin
            if (ovf_reg)
            begin
                v_next  = sum_reg[W-1] ? VAL_MIN : VAL_MAX;
                st_next = ST_SAT;
            end
        end
        else if (den == '0)
        begin
            v_next  = num[W-1] ? VAL_MIN : VAL_MAX;
            st_next = ST_DIV0;
        end
        else if (ovf_reg)
        begin
            v_next  = qneg ? VAL_MIN : VAL_MAX;
            st_next = ST_SAT;
        end
    end

    assign stat.term_small = mag64(term_reg) <= W'(thr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(op_in);
            x_reg   <= x_ext;
            ovf_reg <= 1'b0;
        end
        if (cmd.load || cmd.init_cos)
        begin
            arg_reg  <= arg_new;
            amag_reg <= arg_abs[AMAG_W-1:0];
            term_reg <= W'(arg_new);
            sum_reg  <= '0;
            k_reg    <= K_W'(3);
            d_reg    <= D_W'(6);
        end
        if (cmd.init_cos)
            s_reg <= sum_reg;
        if (cmd.add_term)
        begin
            sum_reg <= sum_new;
            if (sum_ovf)
                ovf_reg <= 1'b1;
        end
        if (cmd.mul_lo)
        begin
            mop_reg  <= src_mag[62:0];
            mneg_reg <= (cmd.mul_sel ? p_reg[W-1] : term_reg[W-1]) ^ arg_reg[ARG_W-1];
            acc_reg  <= ACC_W'(plo);
        end
        if (cmd.mul_hi)
            acc_reg <= acc_reg + {phi, 32'b0};
        if (cmd.mul_rnd)
        begin
            p_reg <= mneg_reg ? -r64 : r64;
            if (r_ovf)
                ovf_reg <= 1'b1;
        end
        if (cmd.div_init)
        begin
            dsh_reg  <= mag64(p_reg) + W'(d_reg >> 1);
            drem_reg <= '0;
            dq_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            dsh_reg  <= dsh;
            drem_reg <= dr[D_W-1:0];
            dq_reg   <= dq;
        end
        if (cmd.div_end)
        begin
            term_reg <= p_reg[W-1] ? dq_reg : -dq_reg;
            k_reg    <= k_nx;
            d_reg    <= {{K_W{1'b0}}, k_nx} * ({{K_W{1'b0}}, k_nx} - D_W'(1));
        end
        if (cmd.q_init)
        begin
            qn_reg   <= {{W{1'b0}}, mag64(num)} << FRAC_BITS;
            qd_reg   <= mag64(den);
            qrem_reg <= '0;
            qq_reg   <= '0;
            big_reg  <= 1'b0;
        end
        if (cmd.q_step)
        begin
            qn_reg   <= {qn_reg[2*W-2:0], 1'b0};
            qrem_reg <= qge ? W'(qsh - {1'b0, qd_reg}) : qsh[W-1:0];
            if (!big_reg)
            begin
                if (qq_reg > Q_BIG)
                    big_reg <= 1'b1;
                else
                    qq_reg <= {qq_reg[Q_W-2:0], qge};
            end
        end
        if (cmd.finish)
        begin
            value_reg  <= v_next;
            status_reg <= st_next;
        end
    end

    assign done   = done_reg;
    assign value  = value_reg;
    assign status = status_reg;

endmodule

>>> hdl/taylor_series_trig_unit.sv
// ----------------------------------------------------------------------------
// taylor_series_trig_unit
// Sine, cosine, tangent and cotangent of a Q4.28 angle by Taylor series.
// ----------------------------------------------------------------------------
//  channel   signals                           transfer when
//  input     start, busy, op, angle            start && !busy
//  result    done, value, status               done (one cycle, no stall)
//  config    psel/penable/pwrite/paddr/pwdata  psel && penable && pwrite
//
//  One item at a time. Each series term takes two passes of the split
//  32x33 multiplier (low half, high half, round) and the radix-16 divider.
//  sin/cos: at most 48 series terms added.
//  tan/cot: both series, then the restoring divider.
//  Reset sets the threshold to 3 and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module taylor_series_trig_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [31:0] value,
    output logic [1:0]         status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tsu_pkg::*;

    logic [15:0] thr_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    // paddr[1:0] are byte lanes within the word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THR_RESET;
        else if (psel && penable && pwrite && paddr[2] == REG_THR)
            thr_reg <= pwdata[15:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THR) ? {16'b0, thr_reg} : 32'b0;

    tsu_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .op_quot (op[1]),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    tsu_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .op_in    (op),
        .angle_in (angle),
        .thr      (thr_reg),
        .stat     (stat),
        .done     (done),
        .value    (value),
        .status   (status)
    );

endmodule

>>> hdl/tsu_chk.sv
// ----------------------------------------------------------------------------
// tsu_chk
// Port-level checks of the trig unit, bound to the top level.
// ----------------------------------------------------------------------------
module tsu_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] value,
    input logic [1:0]         status
);
    import tsu_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not make the unit busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_SAT || status == ST_DIV0))
        else $error("undefined status code");

    a_div0_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ST_DIV0) |-> (value == VAL_MAX || value == VAL_MIN))
        else $error("zero divisor without saturated value");

endmodule

bind taylor_series_trig_unit tsu_chk u_tsu_chk (.*);
